// ----- design/lsbe_pkg.sv -----
package lsbe_pkg;

  localparam int SLOT_W  = 4;
  localparam int SIZE_W  = 40;
  localparam int TOTAL_W = 48;
  localparam int STAMP_W = 32;

  localparam int ENTRIES_DEFAULT = 16;

  localparam logic [STAMP_W-1:0] STAMP_RESET = 32'h0000_0100;
  localparam logic [TOTAL_W-1:0] MIN_BUDGET  = 48'h0000_4000_0000;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_UNMAP  = 3'd1,
    REQ_LOCK   = 3'd2,
    REQ_UNLOCK = 3'd3,
    REQ_TOUCH  = 3'd4,
    REQ_TRIM   = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_ALL_LOCK = 2'd1,
    STS_BAD_SLOT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SINGLE,
    ST_SCAN,
    ST_DECIDE,
    ST_PLACE
  } state_t;

endpackage

// ----- design/lru_segment_budget_evictor.sv -----
// Channel  | handshake                | payload
// ---------+--------------------------+---------------------------------------------
// in       | in_valid / in_stall      | req_type, slot, seg_size
// out      | out_valid / out_stall    | evicted, victim_slot, victim_size, new_slot,
//          |                          | status, total_size, last
// cfg      | max_total_we             | max_total_wdata
//
// Unmap, lock, unlock and touch pass through ST_DISPATCH and ST_SINGLE before the next
// acceptance, unknown requests through ST_DISPATCH only. Insert and trim scan the entry
// memory once per eviction decision (ST_SCAN, then ST_DECIDE), and each eviction rescans;
// a full table that evicts for placement also passes through ST_PLACE.
// in_stall is high while a request is in work; a held result (out_stall) keeps it high longer.
// Reset is synchronous, clears the table, the total and the budget, and sets the stamp counter to STAMP_RESET.
module lru_segment_budget_evictor #(
  parameter int ENTRIES = lsbe_pkg::ENTRIES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    req_type,
  input  logic [lsbe_pkg::SLOT_W-1:0]   slot,
  input  logic [lsbe_pkg::SIZE_W-1:0]   seg_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          evicted,
  output logic [lsbe_pkg::SLOT_W-1:0]   victim_slot,
  output logic [lsbe_pkg::SIZE_W-1:0]   victim_size,
  output logic [lsbe_pkg::SLOT_W-1:0]   new_slot,
  output logic [1:0]                    status,
  output logic [lsbe_pkg::TOTAL_W-1:0]  total_size,
  output logic                          last,
  input  logic                          max_total_we,
  input  logic [lsbe_pkg::TOTAL_W-1:0]  max_total_wdata
);
  import lsbe_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // table storage
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];
  logic [SIZE_W-1:0]  bytes_mem [ENTRIES];
  logic [STAMP_W-1:0] rd_stamp;
  logic [SIZE_W-1:0]  rd_bytes;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_stamp_en;
  logic               wr_bytes_en;
  logic [STAMP_W-1:0] wr_stamp;

  state_t state, state_next;
  req_t   req_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SIZE_W-1:0] size_q;
  logic [IDX_W-1:0]  slot_idx;
  logic              slot_ok;

  logic [ENTRIES-1:0] valid, valid_next;
  logic [ENTRIES-1:0] locked, locked_next;
  logic [STAMP_W-1:0] stamp_ctr, stamp_ctr_next;
  logic [TOTAL_W-1:0] total, total_next;
  logic [TOTAL_W-1:0] budget;

  // scan
  logic [IDX_W-1:0]   cnt, cnt_next;
  logic               issue, issue_next;
  logic               pend, pend_next;
  logic [IDX_W-1:0]   pend_idx, pend_idx_next;
  logic               lru_found, lru_found_next;
  logic [IDX_W-1:0]   lru_idx, lru_idx_next;
  logic [STAMP_W-1:0] lru_stamp, lru_stamp_next;
  logic [SIZE_W-1:0]  lru_bytes, lru_bytes_next;
  logic               free_found, free_found_next;
  logic [IDX_W-1:0]   free_idx, free_idx_next;

  logic [SIZE_W-1:0]  add_size;
  logic               over_budget;

  // result
  logic               emit;
  logic               e_evicted;
  logic [SLOT_W-1:0]  e_vslot;
  logic [SIZE_W-1:0]  e_vsize;
  logic [SLOT_W-1:0]  e_nslot;
  status_t            e_status;
  logic               e_last;
  logic               can_emit;
  logic               out_valid_next;
  status_t            status_q;

  assign in_stall = (state != ST_IDLE);
  assign can_emit = !out_valid || !out_stall;
  assign slot_idx = IDX_W'(slot_q);
  assign slot_ok  = (int'(slot_q) < ENTRIES) && valid[slot_idx];
  assign rd_addr  = (state == ST_SCAN) ? cnt : slot_idx;
  assign add_size = (req_q == REQ_INSERT) ? size_q : '0;
  assign over_budget = (budget != '0) &&
      (({1'b0, total} + (TOTAL_W + 1)'(add_size)) > {1'b0, budget});
  assign status = status_q;

  always_ff @(posedge clk) begin
    rd_stamp <= stamp_mem[rd_addr];
    rd_bytes <= bytes_mem[rd_addr];
    if (wr_stamp_en) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
    if (wr_bytes_en) begin
      bytes_mem[wr_addr] <= size_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      locked    <= '0;
      stamp_ctr <= STAMP_RESET;
      total     <= '0;
      budget    <= '0;
      issue     <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      valid     <= valid_next;
      locked    <= locked_next;
      stamp_ctr <= stamp_ctr_next;
      total     <= total_next;
      issue     <= issue_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
      if (max_total_we) begin
        budget <= (max_total_wdata != '0 && max_total_wdata < MIN_BUDGET) ?
                  MIN_BUDGET : max_total_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt        <= cnt_next;
    pend_idx   <= pend_idx_next;
    lru_found  <= lru_found_next;
    lru_idx    <= lru_idx_next;
    lru_stamp  <= lru_stamp_next;
    lru_bytes  <= lru_bytes_next;
    free_found <= free_found_next;
    free_idx   <= free_idx_next;
    if (state == ST_IDLE && in_valid) begin
      req_q  <= req_t'(req_type);
      slot_q <= slot;
      size_q <= seg_size;
    end
    if (emit) begin
      evicted     <= e_evicted;
      victim_slot <= e_vslot;
      victim_size <= e_vsize;
      new_slot    <= e_nslot;
      status_q    <= e_status;
      total_size  <= total_next;
      last        <= e_last;
    end
  end

  always_comb begin
    state_next      = state;
    valid_next      = valid;
    locked_next     = locked;
    stamp_ctr_next  = stamp_ctr;
    total_next      = total;
    cnt_next        = cnt;
    issue_next      = issue;
    pend_next       = pend;
    pend_idx_next   = pend_idx;
    lru_found_next  = lru_found;
    lru_idx_next    = lru_idx;
    lru_stamp_next  = lru_stamp;
    lru_bytes_next  = lru_bytes;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    wr_addr         = slot_idx;
    wr_stamp_en     = 1'b0;
    wr_bytes_en     = 1'b0;
    wr_stamp        = stamp_ctr + 1'b1;
    emit            = 1'b0;
    e_evicted       = 1'b0;
    e_vslot         = '0;
    e_vsize         = '0;
    e_nslot         = '0;
    e_status        = STS_OK;
    e_last          = 1'b1;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        case (req_q)
          REQ_INSERT, REQ_TRIM: begin
            state_next      = ST_SCAN;
            cnt_next        = '0;
            issue_next      = 1'b1;
            pend_next       = 1'b0;
            lru_found_next  = 1'b0;
            free_found_next = 1'b0;
          end
          REQ_UNMAP, REQ_LOCK, REQ_UNLOCK, REQ_TOUCH: begin
            state_next = ST_SINGLE;
          end
          default: begin
            if (can_emit) begin
              emit       = 1'b1;
              state_next = ST_IDLE;
            end
          end
        endcase
      end

      ST_SINGLE: begin
        if (can_emit) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          if (!slot_ok) begin
            e_status = STS_BAD_SLOT;
          end else begin
            case (req_q)
              REQ_UNMAP: begin
                e_vslot               = slot_q;
                e_vsize               = rd_bytes;
                valid_next[slot_idx]  = 1'b0;
                locked_next[slot_idx] = 1'b0;
                total_next            = total - TOTAL_W'(rd_bytes);
              end
              REQ_LOCK:   locked_next[slot_idx] = 1'b1;
              REQ_UNLOCK: locked_next[slot_idx] = 1'b0;
              REQ_TOUCH: begin
                stamp_ctr_next = stamp_ctr + 1'b1;
                wr_stamp_en    = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end

      ST_SCAN: begin
        if (issue) begin
          pend_next     = 1'b1;
          pend_idx_next = cnt;
          if (cnt == LAST_IDX) begin
            issue_next = 1'b0;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          if (valid[pend_idx] && !locked[pend_idx] &&
              (!lru_found || rd_stamp < lru_stamp)) begin
            lru_found_next = 1'b1;
            lru_idx_next   = pend_idx;
            lru_stamp_next = rd_stamp;
            lru_bytes_next = rd_bytes;
          end
          if (!valid[pend_idx] && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = pend_idx;
          end
          if (pend_idx == LAST_IDX) begin
            state_next = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        if (can_emit) begin
          emit = 1'b1;
          if (over_budget && lru_found) begin
            // evict and rescan
            e_evicted            = 1'b1;
            e_last               = 1'b0;
            e_vslot              = SLOT_W'(lru_idx);
            e_vsize              = lru_bytes;
            valid_next[lru_idx]  = 1'b0;
            locked_next[lru_idx] = 1'b0;
            total_next           = total - TOTAL_W'(lru_bytes);
            state_next           = ST_SCAN;
            cnt_next             = '0;
            issue_next           = 1'b1;
            pend_next            = 1'b0;
            lru_found_next       = 1'b0;
            free_found_next      = 1'b0;
          end else if (req_q == REQ_TRIM) begin
            state_next = ST_IDLE;
          end else if (free_found) begin
            e_nslot               = SLOT_W'(free_idx);
            wr_addr               = free_idx;
            wr_stamp_en           = 1'b1;
            wr_bytes_en           = 1'b1;
            stamp_ctr_next        = stamp_ctr + 1'b1;
            valid_next[free_idx]  = 1'b1;
            locked_next[free_idx] = 1'b0;
            total_next            = total + TOTAL_W'(size_q);
            state_next            = ST_IDLE;
          end else if (lru_found) begin
            // table full: evict one more, then place there
            e_evicted            = 1'b1;
            e_last               = 1'b0;
            e_vslot              = SLOT_W'(lru_idx);
            e_vsize              = lru_bytes;
            valid_next[lru_idx]  = 1'b0;
            locked_next[lru_idx] = 1'b0;
            total_next           = total - TOTAL_W'(lru_bytes);
            state_next           = ST_PLACE;
          end else begin
            e_status   = STS_ALL_LOCK;
            state_next = ST_IDLE;
          end
        end
      end

      ST_PLACE: begin
        if (can_emit) begin
          emit                 = 1'b1;
          e_nslot              = SLOT_W'(lru_idx);
          wr_addr              = lru_idx;
          wr_stamp_en          = 1'b1;
          wr_bytes_en          = 1'b1;
          stamp_ctr_next       = stamp_ctr + 1'b1;
          valid_next[lru_idx]  = 1'b1;
          locked_next[lru_idx] = 1'b0;
          total_next           = total + TOTAL_W'(size_q);
          state_next           = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase

    if (emit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule
